// ----- rtl/mbtk_pkg.sv -----
// Package for the metronome beat and tempo-key core: sequencer states,
// event codes, key flag bits and timing constants.
// No dependencies.
`timescale 1ns / 1ps

package mbtk_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    ACT_FAST_TICK = 2'd0,
    ACT_SCAN_TICK = 2'd1,
    ACT_UP_PRESS  = 2'd2,
    ACT_DOWN_PRESS = 2'd3
  } action_t;

  localparam int unsigned TEMPO_W = 10;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PHASE_W = 9;

  localparam logic [PERIOD_W-1:0] MINUTE_MS = 16'd60000;
  localparam logic [PERIOD_W-1:0] PULSE_MS = 16'd100;
  localparam logic [PHASE_W-1:0] STEP_SCANS = 9'd500;
  localparam logic [PERIOD_W-1:0] FAST_SCANS = 16'd5000;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 10'd120;
  localparam logic [TEMPO_W-1:0] MAX_BPM_RESET = 10'd240;

  localparam logic [1:0] FLAG_UP = 2'h1;
  localparam logic [1:0] FLAG_DOWN = 2'h2;

  localparam logic [2:0] STEP_SLOW = 3'd1;
  localparam logic [2:0] STEP_FAST = 3'd5;

endpackage

// ----- rtl/metronome_beat_and_tempo_keys_core.sv -----
// Metronome core: beat timer, tempo keys, serial period divider, APB register.
// Depends on mbtk_pkg.
`timescale 1ns / 1ps

// Metronome beat generator with up/down tempo keys. Each beat on the input
// channel is one event: a fast tick (four make one millisecond), a key-scan
// tick, an up-key press or a down-key press. Every event yields exactly one
// result beat carrying the beat pin level (low during the 100 ms pulse) and
// the current tempo. A fast tick runs the beat period 60000 / tempo through
// a restoring divider, one quotient bit per cycle, so it passes through
// accept, 16 divide steps and a compare before its result shows up; scan
// ticks and key presses finish in the accept cycle. Input stall stays high
// while an event is in the divider or a result waits on the output, so the
// core takes no new event until the sink has taken the last result. A held
// key steps tempo by 1 at scans 0, 500,
// ..., 4500 of the hold and by 5 every 500 scans after; tempo is clamped to
// 1..max_bpm (a zero max_bpm acts as 1). max_bpm sits at APB address 0,
// resets to 240, and a smaller value takes effect at the next tempo change.
module metronome_beat_and_tempo_keys_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // input beats
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic       in_up_key_held,
  input  logic       in_down_key_held,
  // result beats
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_beat_level,
  output logic [9:0] out_tempo,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned TW = mbtk_pkg::TEMPO_W;
  localparam int unsigned PW = mbtk_pkg::PERIOD_W;
  localparam int unsigned HW = mbtk_pkg::PHASE_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  mbtk_pkg::seq_state_t state_r, state_nxt;

  logic [1:0]             prescale_r, prescale_nxt;
  logic [COUNT_WIDTH-1:0] ms_count_r, ms_count_nxt;
  logic                   pulse_r, pulse_nxt;
  logic                   beat_r, beat_nxt;
  logic [1:0]             flags_r, flags_nxt;
  logic [COUNT_WIDTH-1:0] up_cnt_r, up_cnt_nxt;
  logic [COUNT_WIDTH-1:0] dn_cnt_r, dn_cnt_nxt;
  logic [HW-1:0]          up_ph_r, up_ph_nxt;
  logic [HW-1:0]          dn_ph_r, dn_ph_nxt;
  logic [TW-1:0]          tempo_r, tempo_nxt;
  logic [TW-1:0]          max_bpm_r;

  // serial divider: remainder, quotient/dividend shift register, step count
  logic [TW:0]            rem_r, rem_nxt;
  logic [PW-1:0]          quo_r, quo_nxt;
  logic [3:0]             step_r, step_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_beat_r, out_beat_nxt;
  logic [TW-1:0]          out_tempo_r, out_tempo_nxt;

  logic                   in_accept;
  logic                   cfg_write;

  // divider datapath
  logic [TW-1:0]          divisor;
  logic [TW:0]            rem_sh;
  logic                   rem_fits;

  // hold-step datapath, shared by both keys
  logic                   sel_up, sel_dn, drop_up, drop_dn;
  logic [COUNT_WIDTH-1:0] hcnt;
  logic [HW-1:0]          hph;
  logic [2:0]             hstep;
  logic signed [TW+1:0]   t_sum;
  logic signed [TW+1:0]   t_hi;
  logic [TW-1:0]          t_clamped;
  logic [COUNT_WIDTH-1:0] hcnt_inc;
  logic [HW-1:0]          hph_inc;

  assign in_stall  = (state_r != mbtk_pkg::ST_IDLE) || out_valid_r;
  assign in_accept = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_beat_level = out_beat_r;
  assign out_tempo      = out_tempo_r;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {{(32-TW){1'b0}}, max_bpm_r};

  // one restoring step: bring down the next dividend bit, try a subtract
  assign divisor  = (tempo_r == '0) ? TW'(1) : tempo_r;
  assign rem_sh   = {rem_r[TW-1:0], quo_r[PW-1]};
  assign rem_fits = rem_sh >= {1'b0, divisor};

  // scan priority: held up key, then held down key, then releases
  assign sel_up  = flags_r[0] && in_up_key_held;
  assign sel_dn  = !sel_up && flags_r[1] && in_down_key_held;
  assign drop_up = !sel_up && !sel_dn && flags_r[0] && !in_up_key_held;
  assign drop_dn = !sel_up && !sel_dn && !drop_up && flags_r[1] && !in_down_key_held;

  assign hcnt  = sel_up ? up_cnt_r : dn_cnt_r;
  assign hph   = sel_up ? up_ph_r : dn_ph_r;
  assign hstep = (hcnt < COUNT_WIDTH'(mbtk_pkg::FAST_SCANS)) ?
                 mbtk_pkg::STEP_SLOW : mbtk_pkg::STEP_FAST;
  assign t_sum = sel_up ? ($signed({2'b00, tempo_r}) + $signed({{(TW-1){1'b0}}, hstep})) :
                          ($signed({2'b00, tempo_r}) - $signed({{(TW-1){1'b0}}, hstep}));
  assign t_hi  = (max_bpm_r == '0) ? (TW+2)'(1) : $signed({2'b00, max_bpm_r});

  // both bounds compare signed, so a step below zero clamps to one
  always_comb begin
    if (t_sum > t_hi) begin
      t_clamped = t_hi[TW-1:0];
    end else if (t_sum < $signed((TW+2)'(1))) begin
      t_clamped = TW'(1);
    end else begin
      t_clamped = t_sum[TW-1:0];
    end
  end

  // hold counter saturates; its mod-500 phase freezes with it
  assign hcnt_inc = (hcnt == CNT_MAX) ? hcnt : hcnt + COUNT_WIDTH'(1);
  assign hph_inc  = (hcnt == CNT_MAX) ? hph :
                    ((hph == mbtk_pkg::STEP_SCANS - HW'(1)) ? '0 : hph + HW'(1));

  always_comb begin
    state_nxt     = state_r;
    prescale_nxt  = prescale_r;
    ms_count_nxt  = ms_count_r;
    pulse_nxt     = pulse_r;
    beat_nxt      = beat_r;
    flags_nxt     = flags_r;
    up_cnt_nxt    = up_cnt_r;
    dn_cnt_nxt    = dn_cnt_r;
    up_ph_nxt     = up_ph_r;
    dn_ph_nxt     = dn_ph_r;
    tempo_nxt     = tempo_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    out_tempo_nxt = out_tempo_r;

    // drop the result once the sink takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mbtk_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_action)
            mbtk_pkg::ACT_FAST_TICK: begin
              // advance the prescaler and count now, compare after the divide
              prescale_nxt = prescale_r + 2'd1;
              if (prescale_r == 2'd3) begin
                ms_count_nxt = ms_count_r + COUNT_WIDTH'(1);
              end
              rem_nxt   = '0;
              quo_nxt   = mbtk_pkg::MINUTE_MS;
              step_nxt  = '0;
              state_nxt = mbtk_pkg::ST_DIV;
            end
            mbtk_pkg::ACT_SCAN_TICK: begin
              if (sel_up || sel_dn) begin
                if (hph == '0) begin
                  tempo_nxt = t_clamped;
                end
                if (sel_up) begin
                  up_cnt_nxt = hcnt_inc;
                  up_ph_nxt  = hph_inc;
                end else begin
                  dn_cnt_nxt = hcnt_inc;
                  dn_ph_nxt  = hph_inc;
                end
              end else if (drop_up) begin
                up_cnt_nxt = '0;
                up_ph_nxt  = '0;
                flags_nxt  = flags_r & ~mbtk_pkg::FLAG_UP;
              end else if (drop_dn) begin
                dn_cnt_nxt = '0;
                dn_ph_nxt  = '0;
                flags_nxt  = flags_r & ~mbtk_pkg::FLAG_DOWN;
              end
              out_valid_nxt = 1'b1;
              out_beat_nxt  = beat_r;
              out_tempo_nxt = tempo_nxt;
            end
            default: begin
              // a press arms one key and restarts both holds
              flags_nxt = (in_action == mbtk_pkg::ACT_UP_PRESS) ?
                          mbtk_pkg::FLAG_UP : mbtk_pkg::FLAG_DOWN;
              up_cnt_nxt    = '0;
              dn_cnt_nxt    = '0;
              up_ph_nxt     = '0;
              dn_ph_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_beat_nxt  = beat_r;
              out_tempo_nxt = tempo_r;
            end
          endcase
        end
      end
      mbtk_pkg::ST_DIV: begin
        rem_nxt  = rem_fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
        quo_nxt  = {quo_r[PW-2:0], rem_fits};
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd15) begin
          state_nxt = mbtk_pkg::ST_DONE;
        end
      end
      mbtk_pkg::ST_DONE: begin
        // quo_r now holds the beat period in ms
        if (ms_count_r >= COUNT_WIDTH'(quo_r)) begin
          beat_nxt     = 1'b0;
          pulse_nxt    = 1'b1;
          ms_count_nxt = '0;
        end else if (pulse_r && ms_count_r == COUNT_WIDTH'(mbtk_pkg::PULSE_MS)) begin
          beat_nxt  = 1'b1;
          pulse_nxt = 1'b0;
        end
        out_valid_nxt = 1'b1;
        out_beat_nxt  = beat_nxt;
        out_tempo_nxt = tempo_r;
        state_nxt     = mbtk_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mbtk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbtk_pkg::ST_IDLE;
      prescale_r  <= '0;
      ms_count_r  <= '0;
      pulse_r     <= 1'b0;
      beat_r      <= 1'b1;
      flags_r     <= '0;
      up_cnt_r    <= '0;
      dn_cnt_r    <= '0;
      up_ph_r     <= '0;
      dn_ph_r     <= '0;
      tempo_r     <= mbtk_pkg::TEMPO_RESET;
      max_bpm_r   <= mbtk_pkg::MAX_BPM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prescale_r  <= prescale_nxt;
      ms_count_r  <= ms_count_nxt;
      pulse_r     <= pulse_nxt;
      beat_r      <= beat_nxt;
      flags_r     <= flags_nxt;
      up_cnt_r    <= up_cnt_nxt;
      dn_cnt_r    <= dn_cnt_nxt;
      up_ph_r     <= up_ph_nxt;
      dn_ph_r     <= dn_ph_nxt;
      tempo_r     <= tempo_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        max_bpm_r <= pwdata[TW-1:0];
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    out_beat_r  <= out_beat_nxt;
    out_tempo_r <= out_tempo_nxt;
  end

endmodule

// ----- tb/tb_metronome_beat_and_tempo_keys_core.sv -----
// Self-checking testbench for the metronome beat and tempo-key core.
// Depends on mbtk_pkg and metronome_beat_and_tempo_keys_core.
`timescale 1ns / 1ps

module tb_metronome_beat_and_tempo_keys_core;

  localparam int unsigned HOLD_W = 16;
  localparam logic [2:0] MAX_BPM_ADDR = 3'd0;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    mbtk_pkg::action_t action;
    logic              up_held;
    logic              down_held;
  } key_event_t;

  typedef struct packed {
    logic                         beat_level;
    logic [mbtk_pkg::TEMPO_W-1:0] tempo;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   in_action = mbtk_pkg::ACT_FAST_TICK;
  logic                         in_up_key_held = 1'b0;
  logic                         in_down_key_held = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_beat_level;
  logic [mbtk_pkg::TEMPO_W-1:0] out_tempo;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [2:0]                   paddr = MAX_BPM_ADDR;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // Beats waiting to be sent, and readings the core owes us, oldest first.
  key_event_t queued_events[$];
  reading_t   expected_readings[$];

  // Shadow copy of the metronome state, at its reset values.
  logic [1:0]                   pre_ticks = '0;
  logic [HOLD_W-1:0]            ms_elapsed = '0;
  logic                         pulse_on = 1'b0;
  logic                         pin_level = 1'b1;
  logic [1:0]                   held_flags = '0;
  logic [HOLD_W-1:0]            up_scans = '0;
  logic [HOLD_W-1:0]            down_scans = '0;
  logic [mbtk_pkg::TEMPO_W-1:0] bpm = mbtk_pkg::TEMPO_RESET;
  logic [mbtk_pkg::TEMPO_W-1:0] bpm_limit = mbtk_pkg::MAX_BPM_RESET;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Driver bookkeeping.
  key_event_t  cur_event;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // Monitor bookkeeping.
  reading_t    oldest_reading;
  logic [7:0]  stall_phase = '0;
  int unsigned stall_mode = 0;

  metronome_beat_and_tempo_keys_core #(
    .COUNT_WIDTH(HOLD_W)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_up_key_held   (in_up_key_held),
    .in_down_key_held (in_down_key_held),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_beat_level   (out_beat_level),
    .out_tempo        (out_tempo),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Count every failure; print only the first few in detail.
  function automatic void report_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // Limit a new tempo to 1..max_bpm; a zero limit acts as one.
  function automatic logic [mbtk_pkg::TEMPO_W-1:0] clamp_bpm(int t);
    int hi;
    hi = int'(bpm_limit);
    if (hi < 1) hi = 1;
    if (t > hi) t = hi;
    if (t < 1) t = 1;
    return mbtk_pkg::TEMPO_W'(t);
  endfunction

  // One scan of a held key: change tempo on every 500th scan of the hold,
  // by one early on and by five once the hold is long. The counter sticks
  // at its top value instead of wrapping.
  function automatic logic [HOLD_W-1:0] hold_scan(logic [HOLD_W-1:0] scans, logic rising);
    int delta;
    if (scans % mbtk_pkg::STEP_SCANS == 0) begin
      delta = (scans < mbtk_pkg::FAST_SCANS) ? int'(mbtk_pkg::STEP_SLOW) :
                                               int'(mbtk_pkg::STEP_FAST);
      bpm = clamp_bpm(rising ? int'(bpm) + delta : int'(bpm) - delta);
    end
    if (scans != '1) scans = scans + 1'b1;
    return scans;
  endfunction

  // Apply one accepted beat to the shadow state and queue the reading
  // the core must return for it.
  function automatic void advance_metronome(key_event_t ev);
    int unsigned period;
    reading_t    r;
    case (ev.action)
      mbtk_pkg::ACT_FAST_TICK: begin
        pre_ticks = pre_ticks + 2'd1;
        if (pre_ticks == 2'd0) ms_elapsed = ms_elapsed + 1'b1;
        period = int'(mbtk_pkg::MINUTE_MS) / ((bpm == '0) ? 1 : int'(bpm));
        // The period test wins, so a period of 100 ms or less keeps the pin low.
        if (ms_elapsed >= period) begin
          pin_level = 1'b0;
          pulse_on = 1'b1;
          ms_elapsed = '0;
        end else if (pulse_on && ms_elapsed == mbtk_pkg::PULSE_MS) begin
          pin_level = 1'b1;
          pulse_on = 1'b0;
        end
      end
      mbtk_pkg::ACT_SCAN_TICK: begin
        // Up key first; the first matching case alone is taken.
        if ((held_flags & mbtk_pkg::FLAG_UP) != 0 && ev.up_held) begin
          up_scans = hold_scan(up_scans, 1'b1);
        end else if ((held_flags & mbtk_pkg::FLAG_DOWN) != 0 && ev.down_held) begin
          down_scans = hold_scan(down_scans, 1'b0);
        end else if ((held_flags & mbtk_pkg::FLAG_UP) != 0 && !ev.up_held) begin
          up_scans = '0;
          held_flags = held_flags & ~mbtk_pkg::FLAG_UP;
        end else if ((held_flags & mbtk_pkg::FLAG_DOWN) != 0 && !ev.down_held) begin
          down_scans = '0;
          held_flags = held_flags & ~mbtk_pkg::FLAG_DOWN;
        end
      end
      mbtk_pkg::ACT_UP_PRESS: begin
        held_flags = mbtk_pkg::FLAG_UP;
        up_scans = '0;
        down_scans = '0;
      end
      default: begin
        held_flags = mbtk_pkg::FLAG_DOWN;
        up_scans = '0;
        down_scans = '0;
      end
    endcase
    r.beat_level = pin_level;
    r.tempo = bpm;
    expected_readings.push_back(r);
  endfunction

  function automatic void queue_event(mbtk_pkg::action_t act, logic up, logic down);
    key_event_t ev;
    ev.action = act;
    ev.up_held = up;
    ev.down_held = down;
    queued_events.push_back(ev);
  endfunction

  // Mostly well-formed press-and-hold sequences and runs of fast ticks,
  // with some fully random beats mixed in.
  task automatic queue_random_mix(int unsigned count);
    int unsigned added;
    int unsigned n;
    int unsigned kind;
    logic        key_up;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        key_up = 1'($urandom_range(0, 1));
        queue_event(key_up ? mbtk_pkg::ACT_UP_PRESS : mbtk_pkg::ACT_DOWN_PRESS,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 12);
        repeat (n) begin
          if ($urandom_range(0, 6) != 0) begin
            queue_event(mbtk_pkg::ACT_SCAN_TICK,
                        key_up ? 1'b1 : 1'($urandom_range(0, 1)),
                        key_up ? 1'($urandom_range(0, 1)) : 1'b1);
          end else begin
            queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
          end
        end
        added += n + 1;
      end else if (kind < 8) begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          queue_event(mbtk_pkg::ACT_FAST_TICK, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
        added += n;
      end else begin
        queue_event(mbtk_pkg::action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        added++;
      end
    end
  endtask

  // Hold until every queued beat is sent and every reading is back, then
  // let the core settle. Check on the falling edge, clear of the driver
  // and the monitor.
  task automatic wait_drained();
    @(negedge clk);
    while (queued_events.size() != 0 || in_valid || expected_readings.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
  endtask

  // Write max_bpm over APB, then read it back. Ends on a falling edge so
  // that the caller can queue beats without racing the driver.
  task automatic write_max_bpm(logic [mbtk_pkg::TEMPO_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_BPM_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The register takes the value at this edge.
    bpm_limit = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata != 32'(value)) report_mismatch("max_bpm read-back", 32'(value), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: send queued beats in bursts of random length with random gaps.
  // A beat stays on the pins, unchanged, until the core takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) advance_metronome(cur_event);
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_events.size() != 0) begin
        cur_event = queued_events.pop_front();
        in_action <= cur_event.action;
        in_up_key_held <= cur_event.up_held;
        in_down_key_held <= cur_event.down_held;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted reading against the oldest expectation,
  // and stall the result channel in modes that change each time stall_phase wraps.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected reading, tempo", 0, 32'(out_tempo));
        end else begin
          oldest_reading = expected_readings.pop_front();
          if (out_beat_level != oldest_reading.beat_level) begin
            report_mismatch("beat_level", 32'(oldest_reading.beat_level),
                            32'(out_beat_level));
          end
          if (out_tempo != oldest_reading.tempo) begin
            report_mismatch("tempo", 32'(oldest_reading.tempo), 32'(out_tempo));
          end
        end
      end
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase == 8'd0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (stall_phase[1:0] == 2'd3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Watchdog: end the run if the core stops making progress.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_metronome_beat_and_tempo_keys_core: FAIL");
    $finish;
  end

  initial begin
    // Directed beats at the reset limit of 240.
    queue_event(mbtk_pkg::ACT_FAST_TICK, 1'b0, 1'b0);
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b1, 1'b1);    // no key flagged: nothing moves
    queue_event(mbtk_pkg::ACT_UP_PRESS, 1'b1, 1'b0);
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b1, 1'b1);    // first scan of the hold: +1
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b1, 1'b0);    // mid-hold: no change
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b0, 1'b1);    // up released: drop its flag
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b1, 1'b0);
    queue_event(mbtk_pkg::ACT_DOWN_PRESS, 1'b0, 1'b1);
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b1, 1'b1);    // down held: -1
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b1, 1'b0);    // down released
    queue_event(mbtk_pkg::ACT_DOWN_PRESS, 1'b1, 1'b1);
    queue_event(mbtk_pkg::ACT_UP_PRESS, 1'b0, 1'b1);     // press replaces the down flag
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b0, 1'b1);    // up released, down not flagged
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b0, 1'b1);
    queue_event(mbtk_pkg::ACT_UP_PRESS, 1'b1, 1'b1);
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b1, 1'b1);
    queue_event(mbtk_pkg::ACT_FAST_TICK, 1'b1, 1'b0);
    queue_event(mbtk_pkg::ACT_FAST_TICK, 1'b0, 1'b1);
    queue_event(mbtk_pkg::ACT_FAST_TICK, 1'b1, 1'b1);
    queue_event(mbtk_pkg::ACT_FAST_TICK, 1'b0, 1'b0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // Top limit: random key holds and fast ticks with the widest range.
    write_max_bpm(10'd600);
    queue_random_mix(140);
    wait_drained();

    // Lower the limit below the tempo: the tempo holds until the next
    // change, made here by the down key, and then clamps to the new limit.
    write_max_bpm(10'd100);
    queue_event(mbtk_pkg::ACT_FAST_TICK, 1'b0, 1'b0);
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b1, 1'b1);
    queue_event(mbtk_pkg::ACT_DOWN_PRESS, 1'b0, 1'b1);
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b0, 1'b1);
    queue_random_mix(90);
    wait_drained();

    // Zero limit acts as one; the down key clamps at the bottom.
    write_max_bpm(10'd0);
    queue_event(mbtk_pkg::ACT_UP_PRESS, 1'b1, 1'b0);
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b1, 1'b0);
    queue_event(mbtk_pkg::ACT_DOWN_PRESS, 1'b0, 1'b1);
    queue_event(mbtk_pkg::ACT_SCAN_TICK, 1'b0, 1'b1);
    queue_random_mix(50);
    wait_drained();

    write_max_bpm(10'd1);
    queue_random_mix(50);
    wait_drained();

    write_max_bpm(mbtk_pkg::TEMPO_W'($urandom_range(2, 599)));
    queue_random_mix(80);
    wait_drained();

    // Give any stray reading time to show up.
    repeat (40) @(posedge clk);
    if (expected_readings.size() != 0) begin
      report_mismatch("readings left over", 0, 32'(expected_readings.size()));
    end
    if (mismatches == 0) begin
      $display("tb_metronome_beat_and_tempo_keys_core: PASS");
    end else begin
      $display("tb_metronome_beat_and_tempo_keys_core: FAIL");
    end
    $finish;
  end

endmodule
